FILE: rtl/rna_pkg.sv
package rna_pkg;

  localparam int unsigned OPERAND_WIDTH = 16;
  localparam int unsigned PW = 2 * OPERAND_WIDTH;
  localparam int unsigned RW = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned MW = OPERAND_WIDTH + 1;
  localparam int unsigned KW = $clog2(MW + 1);
  localparam int unsigned CW = $clog2(MW);

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_DIV  = 3'd2,
    ACT_INC  = 3'd3,
    ACT_DEC  = 3'd4,
    ACT_NORM = 3'd5,
    ACT_CMP  = 3'd6
  } action_e;

endpackage

FILE: rtl/rational_number_alu.sv
// Rational number ALU: one operation on two signed fractions a_num/a_den and b_num/b_den.
// Request channel: drive action_i and the four operand ports and raise start while busy
// is low; the request is taken at that clock edge and busy rises on the next cycle
// unless the result is already shown then.
// Result channel: done_o is high for exactly one cycle with res_num_o, res_den_o, the
// compare flags and zero_den_error_o; the receiver cannot stall, so sample it then.
// Paths from the accepting edge to the done_o cycle:
//   increment, decrement, unknown codes and normalize of a zero denominator: the result
//   is registered at the accepting edge (no pass through the unit).
//   divide and compare: states MUL_X, MUL_Y; add and subtract: MUL_X, MUL_Y, MUL_D (one
//   shared 16x16 multiplier, one cross product per cycle).
//   normalize: binary gcd steps on the magnitudes, then a restoring divider runs
//   17 steps for the numerator and 17 for the denominator.
// One request is in flight at a time; a new request may be taken in the cycle that
// done_o is shown. A zero computed denominator is replaced by 1 and flagged.
// Reset clears the sequencer to idle and drops done_o; no result is pending after it.
module rational_number_alu (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic        [2:0]                      action_i,
  input  logic signed [rna_pkg::OPERAND_WIDTH-1:0] a_num_i,
  input  logic signed [rna_pkg::OPERAND_WIDTH-1:0] a_den_i,
  input  logic signed [rna_pkg::OPERAND_WIDTH-1:0] b_num_i,
  input  logic signed [rna_pkg::OPERAND_WIDTH-1:0] b_den_i,
  output logic                                   done_o,
  output logic signed [rna_pkg::RW-1:0]          res_num_o,
  output logic signed [rna_pkg::RW-1:0]          res_den_o,
  output logic                                   is_greater_o,
  output logic                                   is_greater_equal_o,
  output logic                                   is_less_o,
  output logic                                   is_not_equal_o,
  output logic                                   zero_den_error_o
);

  localparam int unsigned W  = rna_pkg::OPERAND_WIDTH;
  localparam int unsigned PW = rna_pkg::PW;
  localparam int unsigned RW = rna_pkg::RW;
  localparam int unsigned MW = rna_pkg::MW;
  localparam int unsigned KW = rna_pkg::KW;
  localparam int unsigned CW = rna_pkg::CW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_X, ST_MUL_Y, ST_MUL_D, ST_GCD, ST_DIV_N, ST_DIV_D
  } state_e;

  state_e               state_q;
  logic [2:0]           act_q;
  logic signed [W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0] x_q, y_q;
  logic [MW-1:0]        u_q, v_q, nmag_q, dmag_q, div_q, rem_q, quo_q, qn_q;
  logic [KW-1:0]        k_q;
  logic [CW-1:0]        cnt_q;
  logic                 nneg_q;

  logic                 done_q, gt_q, ge_q, lt_q, ne_q, err_q;
  logic signed [RW-1:0] num_q, den_q;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;

  always_comb begin
    case (state_q)
      ST_MUL_X: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
      ST_MUL_Y: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  logic [MW:0]   r2;
  logic          r_ge;
  logic [MW-1:0] rem_d, quo_d;
  assign r2    = {rem_q, quo_q[MW-1]};
  assign r_ge  = r2 >= {1'b0, div_q};
  assign rem_d = r_ge ? MW'(r2 - {1'b0, div_q}) : r2[MW-1:0];
  assign quo_d = {quo_q[MW-2:0], r_ge};

  logic signed [MW-1:0] an_x, ad_x, n_x;
  assign an_x = MW'(a_num_i);
  assign ad_x = MW'(a_den_i);
  assign n_x  = a_den_i[W-1] ? -an_x : an_x;

  logic signed [RW-1:0] fin_num, fin_den;
  logic                 fin_fix;

  always_comb begin
    fin_num = '0;
    fin_den = RW'(1);
    fin_fix = 1'b1;
    case (state_q)
      ST_IDLE: begin
        case (action_i)
          rna_pkg::ACT_INC: begin
            fin_num = RW'(a_num_i) + RW'(a_den_i);
            fin_den = RW'(a_den_i);
          end
          rna_pkg::ACT_DEC: begin
            fin_num = RW'(a_num_i) - RW'(a_den_i);
            fin_den = RW'(a_den_i);
          end
          rna_pkg::ACT_NORM: begin
            fin_num = RW'(a_num_i);
            fin_den = '0;
          end
          default: fin_fix = 1'b0;
        endcase
      end
      ST_MUL_Y: begin
        fin_num = RW'(x_q);
        fin_den = RW'(prod);
        fin_fix = (act_q == rna_pkg::ACT_DIV);
      end
      ST_MUL_D: begin
        fin_num = (act_q == rna_pkg::ACT_ADD) ? RW'(x_q) + RW'(y_q) : RW'(x_q) - RW'(y_q);
        fin_den = RW'(prod);
      end
      default: begin
        fin_num = nneg_q ? -RW'({1'b0, qn_q}) : RW'({1'b0, qn_q});
        fin_den = RW'({1'b0, quo_d});
      end
    endcase
  end

  logic fin_zero;
  assign fin_zero = fin_fix && (fin_den == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      gt_q    <= 1'b0;
      ge_q    <= 1'b0;
      lt_q    <= 1'b0;
      ne_q    <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            act_q <= action_i;
            an_q  <= a_num_i;
            ad_q  <= a_den_i;
            bn_q  <= b_num_i;
            bd_q  <= b_den_i;
            if (action_i == rna_pkg::ACT_ADD || action_i == rna_pkg::ACT_SUB ||
                action_i == rna_pkg::ACT_DIV || action_i == rna_pkg::ACT_CMP) begin
              state_q <= ST_MUL_X;
            end else if (action_i == rna_pkg::ACT_NORM && a_den_i != '0) begin
              nneg_q  <= n_x[MW-1];
              nmag_q  <= n_x[MW-1] ? MW'(-n_x) : MW'(n_x);
              u_q     <= n_x[MW-1] ? MW'(-n_x) : MW'(n_x);
              dmag_q  <= a_den_i[W-1] ? MW'(-ad_x) : MW'(ad_x);
              v_q     <= a_den_i[W-1] ? MW'(-ad_x) : MW'(ad_x);
              k_q     <= '0;
              state_q <= ST_GCD;
            end else begin
              done_q <= 1'b1;
              num_q  <= fin_num;
              den_q  <= fin_zero ? RW'(1) : fin_den;
              err_q  <= fin_zero;
              gt_q   <= 1'b0;
              ge_q   <= 1'b0;
              lt_q   <= 1'b0;
              ne_q   <= 1'b0;
            end
          end
        end
        ST_MUL_X: begin
          x_q     <= prod;
          state_q <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          y_q <= prod;
          if (act_q == rna_pkg::ACT_DIV || act_q == rna_pkg::ACT_CMP) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            err_q   <= fin_zero;
            if (act_q == rna_pkg::ACT_CMP) begin
              num_q <= '0;
              den_q <= RW'(1);
              gt_q  <= (ad_q[W-1] == bd_q[W-1]) ? (x_q > prod) : (x_q < prod);
              ge_q  <= ((ad_q[W-1] == bd_q[W-1]) ? (x_q > prod) : (x_q < prod)) ||
                       (x_q == prod);
              lt_q  <= !(((ad_q[W-1] == bd_q[W-1]) ? (x_q > prod) : (x_q < prod)) ||
                         (x_q == prod));
              ne_q  <= (x_q != prod);
            end else begin
              num_q <= fin_num;
              den_q <= fin_zero ? RW'(1) : fin_den;
              gt_q  <= 1'b0;
              ge_q  <= 1'b0;
              lt_q  <= 1'b0;
              ne_q  <= 1'b0;
            end
          end else begin
            state_q <= ST_MUL_D;
          end
        end
        ST_MUL_D: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
          num_q   <= fin_num;
          den_q   <= fin_zero ? RW'(1) : fin_den;
          err_q   <= fin_zero;
          gt_q    <= 1'b0;
          ge_q    <= 1'b0;
          lt_q    <= 1'b0;
          ne_q    <= 1'b0;
        end
        ST_GCD: begin
          if (u_q == '0 || v_q == '0) begin
            div_q   <= MW'((u_q | v_q) << k_q);
            quo_q   <= nmag_q;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV_N;
          end else if (!u_q[0] && !v_q[0]) begin
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
            k_q <= k_q + KW'(1);
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (u_q >= v_q) begin
            u_q <= u_q - v_q;
          end else begin
            v_q <= v_q - u_q;
          end
        end
        ST_DIV_N: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(MW - 1)) begin
            qn_q    <= quo_d;
            quo_q   <= dmag_q;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV_D;
          end else begin
            quo_q <= quo_d;
            rem_q <= rem_d;
          end
        end
        ST_DIV_D: begin
          cnt_q <= cnt_q + CW'(1);
          quo_q <= quo_d;
          rem_q <= rem_d;
          if (cnt_q == CW'(MW - 1)) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            num_q   <= fin_num;
            den_q   <= fin_den;
            err_q   <= 1'b0;
            gt_q    <= 1'b0;
            ge_q    <= 1'b0;
            lt_q    <= 1'b0;
            ne_q    <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy               = (state_q != ST_IDLE);
  assign done_o             = done_q;
  assign res_num_o          = num_q;
  assign res_den_o          = den_q;
  assign is_greater_o       = gt_q;
  assign is_greater_equal_o = ge_q;
  assign is_less_o          = lt_q;
  assign is_not_equal_o     = ne_q;
  assign zero_den_error_o   = err_q;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");
  a_req_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("request dropped");
  a_err_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_den_error_o) |-> (res_den_o == RW'(1))) else $error("bad den fix");
  a_gt_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(is_greater_o && is_less_o)) else $error("greater and less");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned N_RANDOM = 1600;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [2:0]  act;
    logic [32:0] num;
    logic [32:0] den;
    logic        gt;
    logic        ge;
    logic        lt;
    logic        ne;
    logic        err;
  } fraction_result_t;

  class fraction_scoreboard;
    fraction_result_t pending_q[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      per_action[8];

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function void note_request(logic [2:0] act, logic signed [15:0] an_i,
                               logic signed [15:0] ad_i, logic signed [15:0] bn_i,
                               logic signed [15:0] bd_i);
      longint an, ad, bn, bd, n, d, x, y, g;
      logic fix;
      fraction_result_t r;
      an = an_i;
      ad = ad_i;
      bn = bn_i;
      bd = bd_i;
      n = 0;
      d = 1;
      fix = 1'b1;
      r.act = act;
      r.gt = 0;
      r.ge = 0;
      r.lt = 0;
      r.ne = 0;
      r.err = 0;
      per_action[act]++;
      case (act)
        rna_pkg::ACT_ADD: begin
          n = an * bd + bn * ad;
          d = ad * bd;
        end
        rna_pkg::ACT_SUB: begin
          n = an * bd - ad * bn;
          d = ad * bd;
        end
        rna_pkg::ACT_DIV: begin
          n = an * bd;
          d = ad * bn;
        end
        rna_pkg::ACT_INC: begin
          n = an + ad;
          d = ad;
        end
        rna_pkg::ACT_DEC: begin
          n = an - ad;
          d = ad;
        end
        rna_pkg::ACT_NORM: begin
          n = an;
          d = ad;
          if (d < 0) begin
            n = -n;
            d = -d;
          end
          if (d > 0) begin
            g = longint'(gcd_of((n < 0) ? -n : n, d));
            n = n / g;
            d = d / g;
          end
        end
        rna_pkg::ACT_CMP: begin
          x = an * bd;
          y = bn * ad;
          r.gt = ((ad < 0) == (bd < 0)) ? (x > y) : (x < y);
          r.ge = r.gt || (x == y);
          r.lt = !r.ge;
          r.ne = (x != y);
          fix = 1'b0;
        end
        default: fix = 1'b0;
      endcase
      if (fix && d == 0) begin
        d = 1;
        r.err = 1'b1;
      end
      r.num = n[32:0];
      r.den = d[32:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [32:0] num, logic [32:0] den, logic gt, logic ge,
                               logic lt, logic ne, logic err);
      fraction_result_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with no request outstanding at %0t", $realtime);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (num !== e.num || den !== e.den || gt !== e.gt || ge !== e.ge || lt !== e.lt ||
          ne !== e.ne || err !== e.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: act %0d exp %h/%h f%b%b%b%b e%b got %h/%h f%b%b%b%b e%b",
                   e.act, e.num, e.den, e.gt, e.ge, e.lt, e.ne, e.err,
                   num, den, gt, ge, lt, ne, err);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [2:0] action_i;
  logic signed [15:0] a_num_i, a_den_i, b_num_i, b_den_i;
  logic done_o;
  logic signed [32:0] res_num_o, res_den_o;
  logic is_greater_o, is_greater_equal_o, is_less_o, is_not_equal_o, zero_den_error_o;

  fraction_scoreboard sb = new();
  int unsigned cycles = 0;

  rational_number_alu u_top (
    .clk_i, .rst_ni, .start, .busy, .action_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .done_o, .res_num_o, .res_den_o, .is_greater_o, .is_greater_equal_o, .is_less_o,
    .is_not_equal_o, .zero_den_error_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rational_number_alu: mismatch");
      $finish;
    end
    if (rst_ni) begin
      if (done_o)
        sb.check_result(res_num_o, res_den_o, is_greater_o, is_greater_equal_o, is_less_o,
                        is_not_equal_o, zero_den_error_o);
      if (start && !busy)
        sb.note_request(action_i, a_num_i, a_den_i, b_num_i, b_den_i);
    end
  end

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hffff;
        endcase
      end
      1, 2, 3: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_den();
    logic [15:0] v;
    if ($urandom_range(0, 19) == 0) return 16'h0000;
    v = pick_operand();
    return (v == 0) ? 16'h0001 : v;
  endfunction

  task automatic send_request(logic [2:0] act, logic [15:0] an, logic [15:0] ad,
                              logic [15:0] bn, logic [15:0] bd);
    action_i <= act;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_gap();
    int unsigned gap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: gap = 0;
      9: gap = $urandom_range(10, 60);
      default: gap = $urandom_range(1, 4);
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
  endtask

  task automatic send_random();
    logic [2:0]  act;
    logic [15:0] an, ad, k;
    act = 3'($urandom_range(0, 7));
    if (act == 7 && $urandom_range(0, 3) != 0) act = rna_pkg::ACT_NORM;
    an = pick_operand();
    ad = pick_den();
    if (act == rna_pkg::ACT_NORM && $urandom_range(0, 1) == 0) begin
      k = 16'($urandom_range(1, 60));
      an = 16'($signed($urandom_range(0, 400)) - 200) * k;
      ad = 16'($signed($urandom_range(0, 400)) - 200) * k;
    end
    send_request(act, an, ad, pick_operand(), pick_den());
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    action_i <= rna_pkg::ACT_ADD;
    a_num_i <= '0;
    a_den_i <= 16'sd1;
    b_num_i <= '0;
    b_den_i <= 16'sd1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(rna_pkg::ACT_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(rna_pkg::ACT_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
    send_request(rna_pkg::ACT_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(rna_pkg::ACT_SUB, 16'h0003, 16'h0000, 16'h0001, 16'h0002);
    send_request(rna_pkg::ACT_DIV, 16'h0005, 16'h0003, 16'h0000, 16'h0007);
    send_request(rna_pkg::ACT_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(rna_pkg::ACT_INC, 16'h7fff, 16'h7fff, 16'h0, 16'h1);
    send_request(rna_pkg::ACT_INC, 16'h0004, 16'h0000, 16'h0, 16'h1);
    send_request(rna_pkg::ACT_DEC, 16'h8000, 16'h7fff, 16'h0, 16'h1);
    send_request(rna_pkg::ACT_DEC, 16'h0002, 16'h0000, 16'h0, 16'h1);
    send_request(rna_pkg::ACT_NORM, 16'h0006, 16'hfffc, 16'h0, 16'h1);
    send_request(rna_pkg::ACT_NORM, 16'h0000, 16'hfff9, 16'h0, 16'h1);
    send_request(rna_pkg::ACT_NORM, 16'h8000, 16'h8000, 16'h0, 16'h1);
    send_request(rna_pkg::ACT_NORM, 16'hfff5, 16'h0000, 16'h0, 16'h1);
    send_request(rna_pkg::ACT_NORM, 16'h8000, 16'h7fff, 16'h0, 16'h1);
    send_request(rna_pkg::ACT_CMP, 16'h0001, 16'h0002, 16'h0001, 16'hfffe);
    send_request(rna_pkg::ACT_CMP, 16'h0001, 16'hfffe, 16'h0002, 16'h0003);
    send_request(rna_pkg::ACT_CMP, 16'h0002, 16'h0004, 16'h0001, 16'h0002);
    send_request(rna_pkg::ACT_CMP, 16'h0003, 16'h0000, 16'h0001, 16'h0002);
    send_request(rna_pkg::ACT_CMP, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(3'd7, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
    drain();

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain();
      else if (i % 200 > 150) start <= start;
      else idle_gap();
      send_random();
    end
    drain();
    repeat (100) @(posedge clk_i);

    $display("Covered %0d results: add %0d sub %0d div %0d inc %0d dec %0d norm %0d cmp %0d",
             sb.checked, sb.per_action[0], sb.per_action[1], sb.per_action[2],
             sb.per_action[3], sb.per_action[4], sb.per_action[5], sb.per_action[6]);
    $display("Unused action code requests: %0d, mismatches: %0d",
             sb.per_action[7], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("rational_number_alu: match");
    else
      $display("rational_number_alu: mismatch");
    $finish;
  end

endmodule

FILE: rational_number_alu.f
rtl/rna_pkg.sv
rtl/rational_number_alu.sv
test/tb_top.sv
